/* hw/rtl/saltags_pkg.sv */
package saltags_pkg;

    localparam int ADDR_W     = 31;
    localparam int STAMP_W    = 32;
    localparam int OFFSET_W   = 5;
    localparam int IDXB_W     = 3;
    localparam int WAYSU_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int WAY_OUT_W  = 2;
    localparam int SET_OUT_W  = 6;
    localparam int NW_W       = 5;

    localparam int DEF_SETS = 64;
    localparam int DEF_WAYS = 4;

    localparam logic [OFFSET_W-1:0] RST_OFFSET_BITS    = 5'd4;
    localparam logic [IDXB_W-1:0]   RST_SET_INDEX_BITS = 3'd6;
    localparam logic [WAYSU_W-1:0]  RST_WAYS_USED      = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_BITS    = 2'd0,
        CFG_SET_INDEX_BITS = 2'd1,
        CFG_WAYS_USED      = 2'd2
    } t_cfg_idx;

endpackage

/* hw/rtl/set_assoc_lru_cache_tags_core.sv */
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+-------------------------------------
// cfg      | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
// in       | in        | i_in_valid/o_in_stall   | i_address
// out      | out       | o_out_valid/i_out_stall | o_hit, o_way, o_set_index, o_tag
//
// One transaction per cycle sustained while the output is not stalled; a result is registered
// in the lookup stage and then in the output register. The set row (tags, stamps, valid bits)
// is read from memory at acceptance and written back when the lookup stage commits; a bypass
// row covers back-to-back accesses to the same set. After reset a clearing pass zeroes the
// valid memory set by set with o_in_stall high; configuration writes are taken at all times.
// A stalled output holds the result; the lookup stage then holds and the input stalls.
module set_assoc_lru_cache_tags_core #(
    parameter int SETS = saltags_pkg::DEF_SETS,
    parameter int WAYS = saltags_pkg::DEF_WAYS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [saltags_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [saltags_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [saltags_pkg::ADDR_W-1:0]      i_address,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_hit,
    output logic [saltags_pkg::WAY_OUT_W-1:0]   o_way,
    output logic [saltags_pkg::SET_OUT_W-1:0]   o_set_index,
    output logic [saltags_pkg::ADDR_W-1:0]      o_tag
);
    import saltags_pkg::*;

    localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int MAX_IB  = $clog2(SETS + 1) - 1;
    localparam int WAYS_P2 = 1 << WAY_W;
    localparam int NODES   = 2 * WAYS_P2 - 1;

    logic [OFFSET_W-1:0] r_offset_bits;
    logic [IDXB_W-1:0]   r_set_index_bits;
    logic [WAYSU_W-1:0]  r_ways_used;

    logic                r_clr_busy;
    logic [SET_W-1:0]    r_clr_idx;
    logic [STAMP_W-1:0]  r_use_clock;

    logic                r_s1_valid;
    logic [SET_W-1:0]    r_s1_set;
    logic [ADDR_W-1:0]   r_s1_tag;
    logic [SET_W-1:0]    n_s1_set;
    logic [ADDR_W-1:0]   n_s1_tag;

    logic [WAYS-1:0][ADDR_W-1:0]  mem_tag [SETS];
    logic [WAYS-1:0][STAMP_W-1:0] mem_stamp [SETS];
    logic [WAYS-1:0]              mem_vld [SETS];

    logic [WAYS-1:0][ADDR_W-1:0]  r_rd_tag, cur_tag, n_byp_tag, r_byp_tag;
    logic [WAYS-1:0][STAMP_W-1:0] r_rd_stamp, cur_stamp, n_byp_stamp, r_byp_stamp;
    logic [WAYS-1:0]              r_rd_vld, cur_vld, n_byp_vld, r_byp_vld;
    logic                         r_byp_valid;
    logic [SET_W-1:0]             r_byp_set;

    logic                r_out_valid;
    logic                r_out_hit;
    logic [WAY_W-1:0]    r_out_way;
    logic [SET_W-1:0]    r_out_set;
    logic [ADDR_W-1:0]   r_out_tag;

    logic                in_accept;
    logic                out_free;
    logic                commit;
    logic [IDXB_W-1:0]   ib_eff;
    logic [NW_W-1:0]     nw_eff;
    logic [ADDR_W-1:0]   sh_addr;
    logic [ADDR_W-1:0]   set_mask;
    logic [OFFSET_W:0]   tag_shift;

    logic [WAYS-1:0]     match;
    logic [WAYS-1:0]     free;
    logic                hit;
    logic                any_free;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    free_way;
    logic [WAY_W-1:0]    victim;

    logic                node_en    [NODES];
    logic [STAMP_W-1:0]  node_stamp [NODES];
    logic [WAY_W-1:0]    node_idx   [NODES];

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign commit      = r_s1_valid && out_free;
    assign o_in_stall  = r_clr_busy || (r_s1_valid && !out_free);
    assign in_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        if ({1'b0, r_set_index_bits} > 4'(MAX_IB)) begin
            ib_eff = IDXB_W'(MAX_IB);
        end else begin
            ib_eff = r_set_index_bits;
        end
        if (r_ways_used == '0) begin
            nw_eff = NW_W'(1);
        end else if (NW_W'(r_ways_used) > NW_W'(WAYS)) begin
            nw_eff = NW_W'(WAYS);
        end else begin
            nw_eff = NW_W'(r_ways_used);
        end
    end

    always_comb begin
        sh_addr   = i_address >> r_offset_bits;
        set_mask  = ADDR_W'((32'd1 << ib_eff) - 32'd1);
        n_s1_set  = SET_W'(sh_addr & set_mask);
        tag_shift = {1'b0, r_offset_bits} + (OFFSET_W + 1)'(ib_eff);
        n_s1_tag  = i_address >> tag_shift;
    end

    always_comb begin
        if (r_byp_valid && r_byp_set == r_s1_set) begin
            cur_tag   = r_byp_tag;
            cur_stamp = r_byp_stamp;
            cur_vld   = r_byp_vld;
        end else begin
            cur_tag   = r_rd_tag;
            cur_stamp = r_rd_stamp;
            cur_vld   = r_rd_vld;
        end
    end

    always_comb begin
        hit_way  = '0;
        free_way = '0;
        for (int w = 0; w < WAYS; w++) begin
            match[w] = cur_vld[w] && (cur_tag[w] == r_s1_tag) && (NW_W'(w) < nw_eff);
            free[w]  = !cur_vld[w] && (NW_W'(w) < nw_eff);
        end
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_way = WAY_W'(w);
            end
            if (free[w]) begin
                free_way = WAY_W'(w);
            end
        end
        hit      = |match;
        any_free = |free;
    end

    always_comb begin
        for (int w = 0; w < WAYS_P2; w++) begin
            node_idx[WAYS_P2 - 1 + w] = WAY_W'(w);
            if (w < WAYS) begin
                node_en[WAYS_P2 - 1 + w]    = NW_W'(w) < nw_eff;
                node_stamp[WAYS_P2 - 1 + w] = cur_stamp[w];
            end else begin
                node_en[WAYS_P2 - 1 + w]    = 1'b0;
                node_stamp[WAYS_P2 - 1 + w] = '0;
            end
        end
        for (int i = WAYS_P2 - 2; i >= 0; i--) begin
            if (node_en[2*i+1] &&
                (!node_en[2*i+2] || node_stamp[2*i+1] <= node_stamp[2*i+2])) begin
                node_en[i]    = 1'b1;
                node_stamp[i] = node_stamp[2*i+1];
                node_idx[i]   = node_idx[2*i+1];
            end else begin
                node_en[i]    = node_en[2*i+2];
                node_stamp[i] = node_stamp[2*i+2];
                node_idx[i]   = node_idx[2*i+2];
            end
        end
    end

    always_comb begin
        priority if (hit) begin
            victim = hit_way;
        end else if (any_free) begin
            victim = free_way;
        end else begin
            victim = node_idx[0];
        end
        n_byp_tag           = cur_tag;
        n_byp_stamp         = cur_stamp;
        n_byp_vld           = cur_vld;
        n_byp_tag[victim]   = r_s1_tag;
        n_byp_stamp[victim] = r_use_clock;
        n_byp_vld[victim]   = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            mem_tag[r_s1_set]   <= n_byp_tag;
            mem_stamp[r_s1_set] <= n_byp_stamp;
        end
        if (in_accept) begin
            r_rd_tag   <= mem_tag[n_s1_set];
            r_rd_stamp <= mem_stamp[n_s1_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem_vld[r_clr_idx] <= '0;
        end else if (commit) begin
            mem_vld[r_s1_set] <= n_byp_vld;
        end
        if (in_accept) begin
            r_rd_vld <= mem_vld[n_s1_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits    <= RST_OFFSET_BITS;
            r_set_index_bits <= RST_SET_INDEX_BITS;
            r_ways_used      <= RST_WAYS_USED;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_OFFSET_BITS: begin
                    r_offset_bits <= i_cfg_data;
                end
                CFG_SET_INDEX_BITS: begin
                    r_set_index_bits <= i_cfg_data[IDXB_W-1:0];
                end
                CFG_WAYS_USED: begin
                    r_ways_used <= i_cfg_data[WAYSU_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_idx   <= '0;
            r_use_clock <= '0;
            r_s1_valid  <= 1'b0;
            r_byp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + SET_W'(1);
                if (r_clr_idx == SET_W'(SETS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (commit) begin
                r_s1_valid <= 1'b0;
            end
            if (commit) begin
                r_use_clock <= r_use_clock + STAMP_W'(1);
                r_byp_valid <= 1'b1;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_set <= n_s1_set;
            r_s1_tag <= n_s1_tag;
        end
        if (commit) begin
            r_byp_set   <= r_s1_set;
            r_byp_tag   <= n_byp_tag;
            r_byp_stamp <= n_byp_stamp;
            r_byp_vld   <= n_byp_vld;
            r_out_hit   <= hit;
            r_out_way   <= victim;
            r_out_set   <= r_s1_set;
            r_out_tag   <= r_s1_tag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_out_hit;
    assign o_way       = WAY_OUT_W'(r_out_way);
    assign o_set_index = SET_OUT_W'(r_out_set);
    assign o_tag       = r_out_tag;

    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> o_in_stall)
        else $error("transaction accepted during valid clearing pass");

    a_commit_to_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_out_valid && r_byp_valid)
        else $error("committed lookup did not reach output and bypass");

    a_clock_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_use_clock == $past(r_use_clock) + STAMP_W'(1))
        else $error("use clock did not advance on commit");

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_s1_valid)
        else $error("accepted transaction lost before lookup");

endmodule
